@@ rtl/xtea_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// XTEA package
// Shared types, register codes and round helper functions for the XTEA core.
// ----------------------------------------------------------------------------
package xtea_pkg;

  localparam logic [31:0] DELTA = 32'h9E37_79B9;

  localparam logic OP_ENCRYPT = 1'b0;
  localparam logic OP_DECRYPT = 1'b1;

  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 32;

  localparam logic [CFG_IDX_W-1:0] REG_KEY0      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_KEY1      = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_KEY2      = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_KEY3      = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_KEY_VALID = 3'd4;

  typedef struct packed {
    logic        opcode;
    logic [31:0] half_first;
    logic [31:0] half_second;
    logic        last_block;
  } in_t;

  typedef struct packed {
    logic [31:0] out_first;
    logic [31:0] out_second;
    logic        status_ok;
    logic        out_last;
  } out_t;

  typedef struct packed {
    logic [3:0][31:0] key;
    logic             valid;
  } key_cfg_t;

  typedef struct packed {
    logic        op;
    logic [31:0] v0;
    logic [31:0] v1;
    logic        ok;
    logic        last;
  } pipe_t;

  function automatic logic [31:0] xtea_mix(input logic [31:0] x);
    return ((x << 4) ^ (x >> 5)) + x;
  endfunction

  // Round sum delta * n modulo 2^32; only ever called on constants.
  function automatic logic [31:0] xtea_round_sum(input int unsigned n);
    logic [63:0] prod;
    prod = 64'(DELTA) * 64'(n);
    return prod[31:0];
  endfunction

endpackage
`default_nettype wire

@@ rtl/xtea_cfg_regs.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// XTEA configuration registers
// Holds the four key words and the key valid flag written over the cfg port.
// ----------------------------------------------------------------------------
module xtea_cfg_regs
  import xtea_pkg::*;
(
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata_i,
  output key_cfg_t                   key_cfg_o
);

  logic [3:0][31:0] key_q;
  logic             key_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_q       <= '0;
      key_valid_q <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_KEY0:      key_q[0]    <= cfg_wdata_i;
        REG_KEY1:      key_q[1]    <= cfg_wdata_i;
        REG_KEY2:      key_q[2]    <= cfg_wdata_i;
        REG_KEY3:      key_q[3]    <= cfg_wdata_i;
        REG_KEY_VALID: key_valid_q <= cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  assign key_cfg_o.key   = key_q;
  assign key_cfg_o.valid = key_valid_q;

endmodule
`default_nettype wire

@@ rtl/xtea_half_round.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// XTEA half-round stage
// One registered Feistel half-round; the round sum and key select are fixed
// per stage, with encrypt and decrypt variants chosen by the beat's opcode.
// ----------------------------------------------------------------------------
module xtea_half_round
  import xtea_pkg::*;
#(
  parameter int unsigned ROUNDS    = 32,
  parameter int unsigned ROUND_IDX = 0,
  parameter int unsigned PHASE     = 0
) (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire key_cfg_t key_cfg_i,
  input  wire logic     valid_i,
  input  wire pipe_t    data_i,
  output logic          valid_o,
  output pipe_t         data_o
);

  // Encryption walks the sum upward from zero, decryption downward from
  // delta * ROUNDS, so each stage sees two fixed sums.
  localparam logic [31:0] EncSum =
      xtea_round_sum((PHASE == 0) ? ROUND_IDX : ROUND_IDX + 1);
  localparam logic [31:0] DecSum =
      xtea_round_sum((PHASE == 0) ? ROUNDS - ROUND_IDX : ROUNDS - ROUND_IDX - 1);
  localparam logic [1:0] EncSel = (PHASE == 0) ? EncSum[1:0] : EncSum[12:11];
  localparam logic [1:0] DecSel = (PHASE == 0) ? DecSum[12:11] : DecSum[1:0];

  logic        valid_q;
  pipe_t       data_q;
  pipe_t       data_d;
  logic        upd_v0;
  logic [31:0] src;
  logic [31:0] tgt;
  logic [31:0] sum;
  logic [31:0] key;
  logic [31:0] tweak;
  logic [31:0] upd;

  always_comb begin
    // Encrypt touches v0 first, decrypt touches v1 first.
    upd_v0 = (data_i.op == OP_ENCRYPT) ? (PHASE == 0) : (PHASE != 0);
    src    = upd_v0 ? data_i.v1 : data_i.v0;
    tgt    = upd_v0 ? data_i.v0 : data_i.v1;
    sum    = (data_i.op == OP_ENCRYPT) ? EncSum : DecSum;
    key    = (data_i.op == OP_ENCRYPT) ? key_cfg_i.key[EncSel] : key_cfg_i.key[DecSel];
    tweak  = xtea_mix(src) ^ (sum + key);
    upd    = (data_i.op == OP_ENCRYPT) ? tgt + tweak : tgt - tweak;

    data_d = data_i;
    if (data_i.ok) begin
      if (upd_v0) begin
        data_d.v0 = upd;
      end else begin
        data_d.v1 = upd;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule
`default_nettype wire

@@ rtl/xtea_block_cipher_core.sv @@
`timescale 1ns / 1ps
`default_nettype none
// The pipeline has one register stage per half-round.
// Throughput is one block per cycle; busy_o stays low and a beat may start every cycle.
// The half-round stage chain sets the latency; the receiver cannot stall the pipeline.
// Reset clears the stage valid bits, the key words and the key valid flag.
// ----------------------------------------------------------------------------
// XTEA block cipher core
// ECB encrypt/decrypt of 64-bit blocks with a 128-bit key in a fully unrolled
// half-round pipeline; blocks pass through unchanged while no key is valid.
// ----------------------------------------------------------------------------
module xtea_block_cipher_core
  import xtea_pkg::*;
#(
  parameter int unsigned ROUNDS = 32
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  start_i,
  output logic                       busy_o,
  input  wire in_t                   in_i,
  output logic                       done_o,
  output out_t                       result_o,
  input  wire logic                  cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata_i
);

  localparam int unsigned NumStages = 2 * ROUNDS;

  key_cfg_t key_cfg;
  logic     stage_valid [NumStages+1];
  pipe_t    stage_data  [NumStages+1];

  xtea_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .key_cfg_o   (key_cfg)
  );

  assign busy_o = 1'b0;

  assign stage_valid[0]     = start_i & ~busy_o;
  assign stage_data[0].op   = in_i.opcode;
  assign stage_data[0].v0   = in_i.half_first;
  assign stage_data[0].v1   = in_i.half_second;
  assign stage_data[0].ok   = key_cfg.valid;
  assign stage_data[0].last = in_i.last_block;

  for (genvar gi = 0; gi < NumStages; gi++) begin : g_stage
    xtea_half_round #(
      .ROUNDS    (ROUNDS),
      .ROUND_IDX (gi / 2),
      .PHASE     (gi % 2)
    ) u_half (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .key_cfg_i (key_cfg),
      .valid_i   (stage_valid[gi]),
      .data_i    (stage_data[gi]),
      .valid_o   (stage_valid[gi+1]),
      .data_o    (stage_data[gi+1])
    );
  end

  assign done_o              = stage_valid[NumStages];
  assign result_o.out_first  = stage_data[NumStages].v0;
  assign result_o.out_second = stage_data[NumStages].v1;
  assign result_o.status_ok  = stage_data[NumStages].ok;
  assign result_o.out_last   = stage_data[NumStages].last;

`ifndef SYNTHESIS
  // Every result beat matches an accepted start, traced back through the stage chain.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(start_i & ~busy_o, NumStages))
    else $error("result beat without a matching start");

  // The last-block flag stays with its own block through the pipeline.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (result_o.out_last == $past(in_i.last_block, NumStages)))
    else $error("last-block flag out of step with its block");

  // Without a valid key the block words come out untouched.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && !result_o.status_ok) |->
      ((result_o.out_first == $past(in_i.half_first, NumStages)) &&
       (result_o.out_second == $past(in_i.half_second, NumStages))))
    else $error("bypassed block was modified");
`endif

endmodule
`default_nettype wire

@@ sim/xtea_block_cipher_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// XTEA block cipher checker
// Watches the block, register and result ports of the XTEA core. It keeps its
// own copy of the key registers, computes the cipher output of every accepted
// block and compares each result beat, field by field, against the oldest
// pending prediction.
// ----------------------------------------------------------------------------
module xtea_block_cipher_checker
  import xtea_pkg::*;
#(
  parameter int unsigned ROUNDS = 32
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  input  logic                  busy_i,
  input  in_t                   blk_i,
  input  logic                  done_i,
  input  out_t                  result_i,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i,
  output int                    mismatches_o,
  output int                    blocks_in_flight_o
);

  localparam int MAX_PRINTED = 20;

  logic [31:0] key_w [4];
  logic        key_ok;
  out_t        cipher_out_q [$];
  out_t        want;
  int          bad_count = 0;
  int          inflight  = 0;

  assign mismatches_o       = bad_count;
  assign blocks_in_flight_o = inflight;

  task automatic report_mismatch(input string msg);
    if (bad_count < MAX_PRINTED) $display("%0t ns: mismatch: %s", $realtime, msg);
    bad_count++;
  endtask

  function automatic logic [31:0] feistel_f(input logic [31:0] x);
    return ((x << 4) ^ (x >> 5)) + x;
  endfunction

  function automatic out_t cipher_result(input in_t blk);
    logic [31:0] v0;
    logic [31:0] v1;
    logic [31:0] sum;
    out_t        res;
    v0 = blk.half_first;
    v1 = blk.half_second;
    if (key_ok) begin
      if (blk.opcode == OP_ENCRYPT) begin
        sum = '0;
        for (int r = 0; r < ROUNDS; r++) begin
          v0  = v0 + (feistel_f(v1) ^ (sum + key_w[sum[1:0]]));
          sum = sum + DELTA;
          v1  = v1 + (feistel_f(v0) ^ (sum + key_w[sum[12:11]]));
        end
      end else begin
        // The decipher sum starts at delta times the round count, mod 2^32.
        sum = DELTA * 32'(ROUNDS);
        for (int r = 0; r < ROUNDS; r++) begin
          v1  = v1 - (feistel_f(v0) ^ (sum + key_w[sum[12:11]]));
          sum = sum - DELTA;
          v0  = v0 - (feistel_f(v1) ^ (sum + key_w[sum[1:0]]));
        end
      end
    end
    res.out_first  = v0;
    res.out_second = v1;
    res.status_ok  = key_ok;
    res.out_last   = blk.last_block;
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 4; i++) key_w[i] = '0;
      key_ok = 1'b0;
      cipher_out_q.delete();
      inflight = 0;
    end else begin
      // Predict with the key as it stands before any write on this edge.
      if (start_i && !busy_i) cipher_out_q.push_back(cipher_result(blk_i));
      if (done_i) begin
        if (cipher_out_q.size() == 0) begin
          report_mismatch("result beat with no block in flight");
        end else begin
          want = cipher_out_q.pop_front();
          if (result_i.out_first !== want.out_first)
            report_mismatch($sformatf("out_first expected %h, got %h",
                                      want.out_first, result_i.out_first));
          if (result_i.out_second !== want.out_second)
            report_mismatch($sformatf("out_second expected %h, got %h",
                                      want.out_second, result_i.out_second));
          if (result_i.status_ok !== want.status_ok)
            report_mismatch($sformatf("status_ok expected %b, got %b",
                                      want.status_ok, result_i.status_ok));
          if (result_i.out_last !== want.out_last)
            report_mismatch($sformatf("out_last expected %b, got %b",
                                      want.out_last, result_i.out_last));
        end
      end
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_KEY0, REG_KEY1, REG_KEY2, REG_KEY3: key_w[cfg_idx_i[1:0]] = cfg_wdata_i;
          REG_KEY_VALID: key_ok = cfg_wdata_i[0];
          default: ;
        endcase
      end
      inflight = cipher_out_q.size();
    end
  end

endmodule

@@ sim/tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// XTEA block cipher core testbench
// Drives directed and random blocks through the core under a series of keys,
// with and without a valid key, and with random gaps between beats. A checker
// beside the core predicts every result; this module gives the verdict.
// ----------------------------------------------------------------------------
module tb;
  import xtea_pkg::*;

  localparam int unsigned ROUNDS      = 32;
  localparam int unsigned PIPE_LAT    = 2 * ROUNDS;
  localparam int          CLK_PERIOD  = 10;
  localparam int          CYCLE_LIMIT = 100000;
  localparam int          PHASES      = 8;
  localparam int          PHASE_ITEMS = 225;

  // Register indexes past the key valid flag; writes there must be ignored.
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  start_i = 1'b0;
  logic                  busy_o;
  in_t                   in_i = '0;
  logic                  done_o;
  out_t                  result_o;
  logic                  cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx_i = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata_i = '0;
  int                    mismatches;
  int                    blocks_in_flight;
  int                    cycle_count = 0;

  xtea_block_cipher_core #(
    .ROUNDS(ROUNDS)
  ) u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (start_i),
    .busy_o     (busy_o),
    .in_i       (in_i),
    .done_o     (done_o),
    .result_o   (result_o),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_wdata_i(cfg_wdata_i)
  );

  xtea_block_cipher_checker #(
    .ROUNDS(ROUNDS)
  ) u_checker (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .start_i           (start_i),
    .busy_i            (busy_o),
    .blk_i             (in_i),
    .done_i            (done_o),
    .result_i          (result_o),
    .cfg_we_i          (cfg_we_i),
    .cfg_idx_i         (cfg_idx_i),
    .cfg_wdata_i       (cfg_wdata_i),
    .mismatches_o      (mismatches),
    .blocks_in_flight_o(blocks_in_flight)
  );

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  function automatic in_t make_block(input logic op, input logic [31:0] a,
                                     input logic [31:0] b, input logic last);
    in_t blk;
    blk.opcode      = op;
    blk.half_first  = a;
    blk.half_second = b;
    blk.last_block  = last;
    return blk;
  endfunction

  function automatic logic [31:0] edge_word();
    logic [31:0] w;
    case ($urandom_range(0, 3))
      0:       w = 32'h0000_0000;
      1:       w = 32'hFFFF_FFFF;
      2:       w = 32'h8000_0000;
      default: w = 32'h7FFF_FFFF;
    endcase
    return w;
  endfunction

  function automatic in_t rand_block();
    in_t blk;
    blk.opcode      = ($urandom_range(0, 1) == 0) ? OP_ENCRYPT : OP_DECRYPT;
    blk.half_first  = ($urandom_range(0, 7) == 0) ? edge_word() : $urandom();
    blk.half_second = ($urandom_range(0, 7) == 0) ? edge_word() : $urandom();
    blk.last_block  = 1'($urandom_range(0, 1));
    return blk;
  endfunction

  // Called on a falling edge; returns on the falling edge after the beat.
  task automatic send_block(input in_t blk, input int gap);
    if (gap > 0) begin
      start_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    start_i <= 1'b1;
    in_i    <= blk;
    do @(posedge clk_i); while (busy_o);
    @(negedge clk_i);
  endtask

  task automatic drain();
    start_i <= 1'b0;
    @(negedge clk_i);
    while (blocks_in_flight != 0) @(negedge clk_i);
    @(negedge clk_i);
  endtask

  // Leaves the write enable high; the caller lowers it after the last write.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] data);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= data;
    @(negedge clk_i);
  endtask

  task automatic load_key(input logic [3:0][31:0] key, input logic [31:0] valid_word,
                          input bit hit_spare);
    drain();
    for (int w = 0; w < 4; w++) write_reg(REG_KEY0 + 3'(w), key[w]);
    if (hit_spare) begin
      for (int i = REG_SPARE_LO; i <= REG_SPARE_HI; i++) write_reg(3'(i), $urandom());
    end
    write_reg(REG_KEY_VALID, valid_word);
    cfg_we_i <= 1'b0;
  endtask

  initial begin
    logic [3:0][31:0] key;
    logic [31:0]      r0;
    logic [31:0]      r1;
    in_t              blk;
    int               left;
    int               burst_len;
    int               gap;
    bit               valid_bit;

    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // No key yet: spare indexes and a key valid word with bit 0 clear.
    for (int i = REG_SPARE_LO; i <= REG_SPARE_HI; i++) write_reg(3'(i), 32'hFFFF_FFFF);
    write_reg(REG_KEY_VALID, 32'hFFFF_FFFE);
    cfg_we_i <= 1'b0;
    send_block(make_block(OP_ENCRYPT, 32'h0000_0000, 32'h0000_0000, 1'b0), 0);
    send_block(make_block(OP_DECRYPT, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1), 0);
    send_block(make_block(OP_ENCRYPT, 32'h8000_0000, 32'h7FFF_FFFF, 1'b1), 1);
    send_block(make_block(OP_DECRYPT, $urandom(), $urandom(), 1'b0), 0);

    // All-zero key, flag set by an all-ones word.
    load_key('0, 32'hFFFF_FFFF, 1'b0);
    send_block(make_block(OP_ENCRYPT, 32'h0000_0000, 32'h0000_0000, 1'b0), 0);
    send_block(make_block(OP_DECRYPT, 32'h0000_0000, 32'h0000_0000, 1'b1), 0);
    send_block(make_block(OP_ENCRYPT, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1), 2);
    send_block(make_block(OP_DECRYPT, 32'hFFFF_FFFF, 32'h8000_0000, 1'b0), 0);

    // All-ones key, then spare writes that must leave it alone.
    load_key({4{32'hFFFF_FFFF}}, 32'h0000_0001, 1'b1);
    send_block(make_block(OP_ENCRYPT, 32'h7FFF_FFFF, 32'h8000_0000, 1'b0), 0);
    send_block(make_block(OP_DECRYPT, 32'h0000_0000, 32'hFFFF_FFFF, 1'b1), 0);
    send_block(make_block(OP_ENCRYPT, 32'h0000_0000, 32'h0000_0000, 1'b0), 3);
    send_block(make_block(OP_DECRYPT, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1), 0);

    // Random key: the same block enciphered and deciphered.
    key = {$urandom(), $urandom(), $urandom(), $urandom()};
    load_key(key, 32'h0000_0001, 1'b0);
    r0 = $urandom();
    r1 = $urandom();
    send_block(make_block(OP_ENCRYPT, r0, r1, 1'b0), 0);
    send_block(make_block(OP_DECRYPT, r0, r1, 1'b1), 0);
    send_block(make_block(OP_ENCRYPT, r1, r0, 1'b0), 0);
    send_block(make_block(OP_DECRYPT, r1, r0, 1'b1), 1);

    // Key still loaded but the flag cleared: blocks pass through.
    load_key(key, 32'h0000_0000, 1'b0);
    send_block(make_block(OP_ENCRYPT, r0, r1, 1'b1), 0);
    send_block(make_block(OP_DECRYPT, r0, r1, 1'b0), 0);

    for (int ph = 0; ph < PHASES; ph++) begin
      case (ph)
        0:       key = '0;
        1:       key = {4{32'hFFFF_FFFF}};
        3:       key = {edge_word(), edge_word(), edge_word(), edge_word()};
        default: key = {$urandom(), $urandom(), $urandom(), $urandom()};
      endcase
      valid_bit = (ph != 5);
      load_key(key, ($urandom() & ~32'h1) | 32'(valid_bit), ph[0]);
      left = PHASE_ITEMS;
      while (left > 0) begin
        // A buffer of a few blocks; the last one is flagged, with rare noise.
        burst_len = $urandom_range(1, 8);
        for (int j = 0; j < burst_len && left > 0; j++) begin
          blk = rand_block();
          blk.last_block = (j == burst_len - 1) ^ ($urandom_range(0, 15) == 0);
          gap = (ph == 2) ? 0 : $urandom_range(0, 3);
          send_block(blk, gap);
          left--;
        end
        if ($urandom_range(0, 31) == 0) drain();
      end
    end

    start_i <= 1'b0;
    while (blocks_in_flight != 0) @(negedge clk_i);
    repeat (PIPE_LAT + 8) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
